/* rtl/mrdp_pkg.sv */
package mrdp_pkg;

    localparam int DATA_W          = 31;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int ACC_W           = 96;
    localparam int MAX_ROW_LENGTH  = 65536;
    localparam int COUNT_W         = $clog2(MAX_ROW_LENGTH + 1);
    localparam int BIT_IDX_W       = $clog2(ACC_W);

    localparam logic [DATA_W-1:0]    MOD_RESET   = DATA_W'(2147483647);
    localparam logic [COUNT_W-1:0]   COUNT_LIMIT = COUNT_W'(MAX_ROW_LENGTH);
    localparam logic [BIT_IDX_W-1:0] BIT_TOP     = BIT_IDX_W'(ACC_W - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACC  = 4'b0010,
        S_RED  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic start_red;
        logic red_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic red_last;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/modular_row_dot_product.sv */
// A word is accepted with its multiply, then added in the 96-bit accumulate; no new
// word is accepted until that accumulate is done. Row end: 96 steps of bit-serial
// restoring reduction over the accumulator, then the output register is loaded once
// it is free; the result becomes valid after the accumulate, the 96 reduction steps
// and the load, which waits while the output is stalled.
// Reset (synchronous, active low): modulus to 2^31-1, accumulator, count,
// overflow flag and output valid cleared.
module modular_row_dot_product (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mrdp_pkg::DATA_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mrdp_pkg::DATA_W-1:0]   i_matrix_entry,
    input  logic [mrdp_pkg::DATA_W-1:0]   i_vector_entry,
    input  logic                          i_last_of_row,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mrdp_pkg::DATA_W-1:0]   o_row_result,
    output logic                          o_row_overflow
);

    mrdp_pkg::t_dp_cmd    cmd;
    mrdp_pkg::t_dp_status status;

    mrdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mrdp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_matrix_entry (i_matrix_entry),
        .i_vector_entry (i_vector_entry),
        .i_last_of_row  (i_last_of_row),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_row_result   (o_row_result),
        .o_row_overflow (o_row_overflow)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.capture, cmd.accumulate, cmd.red_step, cmd.load_out}))
        else $error("datapath commands overlap");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over an unread word");

    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && cmd.accumulate))
        else $error("accepted word not accumulated in the next cycle");

endmodule

/* rtl/mrdp_ctrl.sv */
module mrdp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mrdp_pkg::t_dp_status  i_status,
    output mrdp_pkg::t_dp_cmd     o_cmd
);

    mrdp_pkg::t_state r_state;
    mrdp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrdp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            mrdp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = mrdp_pkg::S_ACC;
                end
            end
            mrdp_pkg::S_ACC: begin
                o_cmd.accumulate = 1'b1;
                if (i_status.last) begin
                    o_cmd.start_red = 1'b1;
                    n_state         = mrdp_pkg::S_RED;
                end else begin
                    n_state = mrdp_pkg::S_IDLE;
                end
            end
            mrdp_pkg::S_RED: begin
                o_cmd.red_step = 1'b1;
                if (i_status.red_last) begin
                    n_state = mrdp_pkg::S_DONE;
                end
            end
            mrdp_pkg::S_DONE: begin
                // hold until the output register can take the word
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mrdp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrdp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/mrdp_dp.sv */
module mrdp_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mrdp_pkg::DATA_W-1:0]   i_cfg_wdata,
    input  logic [mrdp_pkg::DATA_W-1:0]   i_matrix_entry,
    input  logic [mrdp_pkg::DATA_W-1:0]   i_vector_entry,
    input  logic                          i_last_of_row,
    input  mrdp_pkg::t_dp_cmd             i_cmd,
    output mrdp_pkg::t_dp_status          o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [mrdp_pkg::DATA_W-1:0]   o_row_result,
    output logic                          o_row_overflow
);

    logic [mrdp_pkg::DATA_W-1:0]    r_modulus;
    logic [mrdp_pkg::PROD_W-1:0]    r_prod;
    logic                           r_last;
    logic [mrdp_pkg::ACC_W-1:0]     r_acc;
    logic [mrdp_pkg::COUNT_W-1:0]   r_count;
    logic                           r_ovf;
    logic [mrdp_pkg::DATA_W-1:0]    r_rem;
    logic [mrdp_pkg::BIT_IDX_W-1:0] r_bit_idx;
    logic                           r_out_valid;
    logic [mrdp_pkg::DATA_W-1:0]    r_out_result;
    logic                           r_out_ovf;

    logic [mrdp_pkg::DATA_W:0]      shifted;
    logic [mrdp_pkg::DATA_W:0]      n_rem_wide;
    logic                           out_free;

    // one bit of restoring reduction: shift in the next bit, subtract once if needed
    always_comb begin
        shifted = {r_rem, r_acc[r_bit_idx]};
        if (shifted >= {1'b0, r_modulus}) begin
            n_rem_wide = shifted - {1'b0, r_modulus};
        end else begin
            n_rem_wide = shifted;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mrdp_pkg::MOD_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_prod <= {{mrdp_pkg::DATA_W{1'b0}}, i_matrix_entry}
                    * {{mrdp_pkg::DATA_W{1'b0}}, i_vector_entry};
            r_last <= i_last_of_row;
        end
        if (i_cmd.start_red) begin
            r_rem     <= '0;
            r_bit_idx <= mrdp_pkg::BIT_TOP;
        end else if (i_cmd.red_step) begin
            r_rem     <= n_rem_wide[mrdp_pkg::DATA_W-1:0];
            r_bit_idx <= r_bit_idx - 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_result <= (r_modulus == '0) ? '0 : r_rem;
            r_out_ovf    <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_acc   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.accumulate) begin
            if (r_count < mrdp_pkg::COUNT_LIMIT) begin
                r_acc   <= r_acc + {{(mrdp_pkg::ACC_W - mrdp_pkg::PROD_W){1'b0}}, r_prod};
                r_count <= r_count + 1'b1;
            end else begin
                // row too long: drop the product, flag it
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.last     = r_last;
    assign o_status.red_last = (r_bit_idx == '0);
    assign o_status.out_free = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_row_result   = r_out_result;
    assign o_row_overflow = r_out_ovf;

endmodule

/* verif/modular_row_dot_product_test.sv */
`timescale 1ns / 1ps

module modular_row_dot_product_test;

    localparam int DW              = mrdp_pkg::DATA_W;
    localparam int ROW_LIMIT       = mrdp_pkg::MAX_ROW_LENGTH;
    localparam int DRAIN_CYCLES    = 120;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int WORDS_PER_SET   = 310;
    localparam int CYCLE_LIMIT     = 3000000;

    typedef enum logic {
        DIR_WORD,
        DIR_MODULUS
    } t_step_kind;

    // For DIR_MODULUS steps the new modulus travels in field a.
    typedef struct packed {
        t_step_kind      kind;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
        logic            last;
        logic [31:0]     reps;
        logic            typed;
        logic [DW-1:0]   residue;
        logic            overflow;
    } t_directed_step;

    typedef struct packed {
        logic [DW-1:0]   residue;
        logic            overflow;
    } t_row_result;

    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            i_cfg_we       = 1'b0;
    logic [DW-1:0]   i_cfg_wdata    = '0;
    logic            i_in_valid     = 1'b0;
    logic            o_in_ready;
    logic [DW-1:0]   i_matrix_entry = '0;
    logic [DW-1:0]   i_vector_entry = '0;
    logic            i_last_of_row  = 1'b0;
    logic            o_out_valid;
    logic            i_out_ready    = 1'b0;
    logic [DW-1:0]   o_row_result;
    logic            o_row_overflow;

    // Predictor state
    logic [DW-1:0]   modulus;
    logic [95:0]     row_sum;
    int unsigned     row_entries;
    bit              row_overflowed;

    t_row_result     expected_rows[$];
    t_directed_step  directed_steps[$];
    t_row_result     oldest_row;

    int              send_idle_pct;
    int              recv_idle_pct;
    bit              hold_off_request;
    int              hold_off_left;
    int              fail_count;
    int              rows_checked;
    int              words_sent;
    int              modulus_writes;
    int              cycle_count;

    modular_row_dot_product dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_matrix_entry (i_matrix_entry),
        .i_vector_entry (i_vector_entry),
        .i_last_of_row  (i_last_of_row),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_row_result   (o_row_result),
        .o_row_overflow (o_row_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d rows outstanding", $realtime, expected_rows.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void add_word(logic [DW-1:0] a, logic [DW-1:0] b, logic last,
                                     int unsigned reps, logic typed,
                                     logic [DW-1:0] residue, logic overflow);
        directed_steps.push_back('{DIR_WORD, a, b, last, reps, typed, residue, overflow});
    endfunction

    function automatic void add_modulus(logic [DW-1:0] value);
        directed_steps.push_back('{DIR_MODULUS, value, '0, 1'b0, 32'd1, 1'b0, '0, 1'b0});
    endfunction

    function automatic logic [DW-1:0] random_entry();
        case ($urandom_range(7))
            0:       return '0;
            1:       return {DW{1'b1}};
            2:       return modulus - 1'b1;
            3:       return DW'($urandom_range(15));
            default: return DW'($urandom);
        endcase
    endfunction

    // Add one product to the exact row sum, or flag the row once it is past the limit; close the row on its last word.
    task automatic accumulate_entry(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                    input logic last, input logic use_typed,
                                    input t_row_result typed_row);
        logic [61:0] prod;
        t_row_result row;
        prod = 62'(a) * 62'(b);
        if (row_entries < ROW_LIMIT) begin
            row_sum = row_sum + {34'd0, prod};
            row_entries++;
        end else begin
            row_overflowed = 1'b1;
        end
        if (last) begin
            row.residue  = (modulus == '0) ? '0 : DW'(row_sum % {65'd0, modulus});
            row.overflow = row_overflowed;
            expected_rows.push_back(use_typed ? typed_row : row);
            row_sum        = '0;
            row_entries    = 0;
            row_overflowed = 1'b0;
        end
    endtask

    task automatic send_word(input logic [DW-1:0] a, input logic [DW-1:0] b,
                             input logic last, input logic use_typed,
                             input t_row_result typed_row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_matrix_entry <= a;
        i_vector_entry <= b;
        i_last_of_row  <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        accumulate_entry(a, b, last, use_typed, typed_row);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_rows_done();
        i_in_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write only with the block idle: drain, then give the reduction time to settle.
    task automatic set_modulus(input logic [DW-1:0] value);
        wait_rows_done();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        modulus      = value;
        modulus_writes++;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_off_request) begin
            hold_off_left    = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
        end
        if (hold_off_left != 0) begin
            i_out_ready <= 1'b0;
            hold_off_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row word: residue %h overflow %0b", $realtime,
                         o_row_result, o_row_overflow);
                fail_count++;
            end else begin
                oldest_row = expected_rows.pop_front();
                rows_checked++;
                if (o_row_result !== oldest_row.residue) begin
                    $display("%0t: row_result expected %h actual %h", $realtime,
                             oldest_row.residue, o_row_result);
                    fail_count++;
                end
                if (o_row_overflow !== oldest_row.overflow) begin
                    $display("%0t: row_overflow expected %0b actual %0b", $realtime,
                             oldest_row.overflow, o_row_overflow);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_directed_step step;
        t_row_result    typed_row;
        logic [DW-1:0]  next_modulus;
        int unsigned    n;
        int             remaining;
        int             row_len;
        bit             paused;

        modulus        = mrdp_pkg::MOD_RESET;
        row_sum        = '0;
        row_entries    = 0;
        row_overflowed = 1'b0;
        send_idle_pct  = 18;
        recv_idle_pct  = 60;
        paused         = 1'b0;

        // Reset modulus 2^31-1: extremes, entries equal to the modulus
        add_word(31'd0, 31'd0, 1'b1, 1, 1'b1, 31'd0, 1'b0);
        add_word(31'd1, 31'd1, 1'b1, 1, 1'b1, 31'd1, 1'b0);
        add_word(31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 1, 1'b1, 31'd0, 1'b0);
        add_word(31'h7FFFFFFE, 31'h7FFFFFFE, 1'b1, 1, 1'b1, 31'd1, 1'b0);
        add_word(31'h7FFFFFFE, 31'd1, 1'b0, 1, 1'b0, 31'd0, 1'b0);
        add_word(31'd1, 31'd1, 1'b1, 1, 1'b1, 31'd0, 1'b0);
        add_word(31'h12345678, 31'h07654321, 1'b0, 1, 1'b0, 31'd0, 1'b0);
        add_word(31'h7FFFFFFF, 31'h7FFFFFFE, 1'b0, 1, 1'b0, 31'd0, 1'b0);
        add_word(31'h55555555, 31'h2AAAAAAA, 1'b1, 1, 1'b0, 31'd0, 1'b0);
        add_word(31'd2, 31'd3, 1'b1, 1, 1'b1, 31'd6, 1'b0);
        add_modulus(31'd0);
        add_word(31'd5, 31'd7, 1'b1, 1, 1'b1, 31'd0, 1'b0);
        add_word(31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 1, 1'b1, 31'd0, 1'b0);
        add_modulus(31'd1);
        add_word(31'h7FFFFFFF, 31'h7FFFFFFE, 1'b1, 1, 1'b1, 31'd0, 1'b0);
        add_modulus(31'd2);
        add_word(31'd3, 31'd5, 1'b1, 1, 1'b1, 31'd1, 1'b0);
        add_modulus(31'd6);
        add_word(31'd5, 31'd5, 1'b1, 1, 1'b1, 31'd1, 1'b0);
        add_modulus(31'd3);
        add_word(31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 1, 1'b0, 31'd0, 1'b0);
        add_modulus(31'h7FFFFFFF);
        add_word(31'h7FFFFFFF, 31'h40000000, 1'b1, 1, 1'b0, 31'd0, 1'b0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            step = directed_steps[i];
            if (step.kind == DIR_MODULUS) begin
                set_modulus(step.a);
            end else begin
                typed_row = '{step.residue, step.overflow};
                for (n = 1; n <= step.reps; n++)
                    send_word(step.a, step.b, step.last && (n == step.reps),
                              step.typed && (n == step.reps), typed_row);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 18 : 0;
            for (int half = 0; half < 2; half++) begin
                case (phase * 2 + half)
                    0:       next_modulus = 31'd2147483629;
                    1:       next_modulus = 31'd2;
                    2:       next_modulus = DW'($urandom) | 31'd1;
                    3:       next_modulus = 31'd65521;
                    4:       next_modulus = DW'($urandom_range(255, 3));
                    default: next_modulus = 31'h7FFFFFFF;
                endcase
                set_modulus(next_modulus);
                // Stall the result side long enough to back the block up
                if (phase == 0 && half == 0)
                    hold_off_request = 1'b1;
                remaining = WORDS_PER_SET;
                while (remaining > 0) begin
                    row_len = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                                       : $urandom_range(12, 1);
                    if (row_len > remaining)
                        row_len = remaining;
                    for (int k = 0; k < row_len; k++)
                        send_word(random_entry(), random_entry(), k == row_len - 1,
                                  1'b0, '0);
                    remaining -= row_len;
                    if (phase == 1 && half == 0 && !paused && remaining < 150) begin
                        wait_rows_done();
                        paused = 1'b1;
                    end
                end
            end
        end

        wait_rows_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d words, checked %0d rows across %0d modulus writes", words_sent,
                 rows_checked, modulus_writes);
        $display("Included entries at and above the modulus, moduli 0, 1, 2 and 2^31-1");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mrdp_pkg.sv
rtl/mrdp_ctrl.sv
rtl/mrdp_dp.sv
rtl/modular_row_dot_product.sv
verif/modular_row_dot_product_test.sv
